/* hw/rtl/sli_pkg.sv */
// ----------------------------------------------------------------------------
// sli_pkg
// Shared widths, operation and status codes, and the control structs that
// pass between the sorted list controller and its datapath.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int KIND_W       = 2;
  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int FILL_W       = 5;
  localparam int CAPACITY_DEF = 16;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch the accepted word, clear dump counter
    logic exec;       // run a single-result op, load output register
    logic dump_step;  // emit head entry, rotate table
  } sli_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dump_list;  // held op is a dump of a non-empty table
    logic out_free;   // output register can take a word this cycle
    logic dump_last;  // current dump step emits the final entry
  } sli_stat_t;

endpackage

/* hw/rtl/sli_in_if.sv */
// ----------------------------------------------------------------------------
// sli_in_if
// Request channel: operation kind and operand value with valid/ready.
// ----------------------------------------------------------------------------
interface sli_in_if
  import sli_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

/* hw/rtl/sli_out_if.sv */
// ----------------------------------------------------------------------------
// sli_out_if
// Result channel: status, entry, fill and last marker with valid/ready.
// ----------------------------------------------------------------------------
interface sli_out_if
  import sli_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] entry;
  logic [FILL_W-1:0]        fill;
  logic                     last;

  modport source (output valid, output status, output entry, output fill,
                  output last, input ready);
  modport sink   (input valid, input status, input entry, input fill,
                  input last, output ready);
endinterface

/* hw/rtl/sli_ctrl.sv */
// ----------------------------------------------------------------------------
// sli_ctrl
// Sequencer: accept a word, run the op, or step through a dump.
// ----------------------------------------------------------------------------
module sli_ctrl
  import sli_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sli_stat_t stat,
  output sli_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_OP   = 3'b010,
    S_DUMP = 3'b100
  } sli_state_t;

  sli_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_OP;
        end
      end
      S_OP: begin
        if (stat.dump_list) begin
          state_nxt = S_DUMP;
        end else if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.dump_step = 1'b1;
          if (stat.dump_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* hw/rtl/sli_dp.sv */
// ----------------------------------------------------------------------------
// sli_dp
// Sorted register row with parallel compares, occupancy count, dump counter
// and the output register.
// ----------------------------------------------------------------------------
module sli_dp
  import sli_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_entry,
  output logic [FILL_W-1:0]        out_fill,
  output logic                     out_last,
  input  sli_cmd_t                 cmd,
  output sli_stat_t                stat
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic [KIND_W-1:0]        kind_r;
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] ent_r   [CAPACITY];
  logic signed [DATA_W-1:0] ent_nxt [CAPACITY];
  logic signed [DATA_W-1:0] ins_new [CAPACITY];
  logic signed [DATA_W-1:0] del_new [CAPACITY];
  logic signed [DATA_W-1:0] rot_new [CAPACITY];
  logic [OCC_W-1:0]         occ_r, occ_nxt, cnt_r;
  logic [CAPACITY-1:0]      keep, lt, hit, top;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      status_r, op_status;
  logic signed [DATA_W-1:0] entry_r;
  logic [FILL_W-1:0]        fill_r;
  logic                     last_r;
  logic                     full, empty, found, wr_ins, wr_del, dump_last;

  assign full      = (occ_r == OCC_W'(CAPACITY));
  assign empty     = (occ_r == '0);
  assign found     = |hit;
  assign dump_last = ((cnt_r + OCC_W'(1)) == occ_r);

  // per-cell compares and next values; table stays sorted so the
  // keep vector is a thermometer code
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic live;
    assign live    = (occ_r > OCC_W'(i));
    assign keep[i] = live && !(ent_r[i] > value_r);
    assign lt[i]   = ent_r[i] < value_r;
    assign hit[i]  = live && (ent_r[i] == value_r);
    assign top[i]  = ((OCC_W'(i) + OCC_W'(1)) == occ_r);

    if (i == 0) begin : g_first
      assign ins_new[i] = keep[i] ? ent_r[i] : value_r;
    end else begin : g_rest
      assign ins_new[i] = keep[i] ? ent_r[i] : (keep[i-1] ? value_r : ent_r[i-1]);
    end

    if (i == CAPACITY - 1) begin : g_last
      assign del_new[i] = ent_r[i];
      assign rot_new[i] = ent_r[0];
    end else begin : g_mid
      assign del_new[i] = lt[i] ? ent_r[i] : ent_r[i+1];
      assign rot_new[i] = top[i] ? ent_r[0] : ent_r[i+1];
    end
  end

  // single-result op outcome
  always_comb begin
    op_status = ST_DONE;
    wr_ins    = 1'b0;
    wr_del    = 1'b0;
    occ_nxt   = occ_r;
    case (kind_r)
      KIND_INSERT: begin
        if (full) begin
          op_status = ST_FULL;
        end else begin
          wr_ins  = 1'b1;
          occ_nxt = occ_r + OCC_W'(1);
        end
      end
      KIND_DELETE: begin
        if (empty) begin
          op_status = ST_EMPTY;
        end else if (!found) begin
          op_status = ST_NOT_FOUND;
        end else begin
          wr_del  = 1'b1;
          occ_nxt = occ_r - OCC_W'(1);
        end
      end
      KIND_DUMP: op_status = ST_EMPTY;  // only an empty dump gets here
      default:   op_status = ST_DONE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.exec && wr_ins)      ent_nxt[i] = ins_new[i];
      else if (cmd.exec && wr_del) ent_nxt[i] = del_new[i];
      else if (cmd.dump_step)      ent_nxt[i] = rot_new[i];
      else                         ent_nxt[i] = ent_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) ent_r[i] <= ent_nxt[i];
    if (cmd.capture) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    if (cmd.exec) begin
      status_r <= op_status;
      entry_r  <= value_r;
      fill_r   <= FILL_W'(occ_nxt);
      last_r   <= 1'b1;
    end else if (cmd.dump_step) begin
      status_r <= ST_DONE;
      entry_r  <= ent_r[0];
      fill_r   <= FILL_W'(occ_r);
      last_r   <= dump_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) occ_r <= occ_nxt;
      if (cmd.capture)        cnt_r <= '0;
      else if (cmd.dump_step) cnt_r <= cnt_r + OCC_W'(1);
      if (cmd.exec || cmd.dump_step) out_valid_r <= 1'b1;
      else if (out_ready)             out_valid_r <= 1'b0;
    end
  end

  assign stat.dump_list = (kind_r == KIND_DUMP) && !empty;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.dump_last = dump_last;

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_entry  = entry_r;
  assign out_fill   = fill_r;
  assign out_last   = last_r;

endmodule

/* hw/rtl/sorted_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Ascending sorted table of signed 32-bit values with insert, delete, dump.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request words {kind, value}. kind insert places value in order
//            (status full if the table holds CAPACITY entries), delete drops
//            the first equal entry (not found / empty), dump streams all.
//   out_ch : result words {status, entry, fill, last}. fill is the entry
//            count after the op; last marks the final word of a request.
// Sequence: a request is taken in the idle state, evaluated in the op state
//   and its result is registered in the output register. A non-empty dump
//   instead enters the dump state and then emits one word per cycle while
//   the output register is free, from the head of the register row, which
//   rotates so the table is back in order after the last word. A new request
//   is accepted only once the sequencer is back in idle.
// Stall: a waiting result does not block acceptance of the next request;
//   evaluation and dump steps pause until the output register frees up.
// Reset: synchronous active-low rst_n empties the table and drops out valid.
//   Entry storage itself is not cleared; it is only read below the count.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete
  import sli_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sli_in_if.sink    in_ch,
  sli_out_if.source out_ch
);

  sli_cmd_t  cmd;
  sli_stat_t stat;
  logic      in_ready;

  // sequencer
  sli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table, compares and output register
  sli_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_kind    (in_ch.kind),
    .in_value   (in_ch.value),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_entry  (out_ch.entry),
    .out_fill   (out_ch.fill),
    .out_last   (out_ch.last),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign in_ch.ready = in_ready;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted list: a directed table of insert, delete,
// dump and unused-kind words, then random bursts that fill, drain and mix the
// table, all checked word by word against a shadow list or a row's own answer.
// ----------------------------------------------------------------------------
module tb_top;
  import sli_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int RAND_WORDS  = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;
  localparam int IDLE_PCT    = 38;

  // kind 3 is not an operation: block echoes value, status done, table kept
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] entry;
    logic [FILL_W-1:0]        fill;
    logic                     last;
  } result_t;

  // one directed row; want is only used when typed is set
  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    int                       reps;
    bit                       typed;
    result_t                  want;
  } dir_row_t;

  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_mode_t;

  localparam int DIR_ROWS = 18;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty table: dump and delete both report empty, value echoed
    '{KIND_DUMP,   32'sh1234_5678, 1, 1'b1, '{ST_EMPTY, 32'sh1234_5678, 5'd0, 1'b1}},
    '{KIND_DELETE, -32'sd1,        1, 1'b1, '{ST_EMPTY, -32'sd1, 5'd0, 1'b1}},
    '{KIND_UNUSED, 32'shDEAD_BEEF, 1, 1'b1, '{ST_DONE, 32'shDEAD_BEEF, 5'd0, 1'b1}},
    // value extremes
    '{KIND_INSERT, VAL_MIN,        1, 1'b1, '{ST_DONE, VAL_MIN, 5'd1, 1'b1}},
    '{KIND_INSERT, VAL_MAX,        1, 1'b1, '{ST_DONE, VAL_MAX, 5'd2, 1'b1}},
    '{KIND_DELETE, 32'sd5,         1, 1'b1, '{ST_NOT_FOUND, 32'sd5, 5'd2, 1'b1}},
    // duplicates and ordering around zero
    '{KIND_INSERT, 32'sd0,         1, 1'b0, '0},
    '{KIND_INSERT, 32'sd0,         1, 1'b0, '0},
    '{KIND_INSERT, -32'sd1,        1, 1'b0, '0},
    '{KIND_DUMP,   32'sd0,         1, 1'b0, '0},
    '{KIND_DELETE, 32'sd0,         1, 1'b0, '0},
    // top up to capacity with one repeated value, then overflow
    '{KIND_INSERT, -32'sd7,       12, 1'b0, '0},
    '{KIND_INSERT, 32'sd42,        1, 1'b1, '{ST_FULL, 32'sd42, 5'd16, 1'b1}},
    '{KIND_DUMP,   32'sd0,         1, 1'b0, '0},
    '{KIND_DELETE, VAL_MIN,        1, 1'b1, '{ST_DONE, VAL_MIN, 5'd15, 1'b1}},
    '{KIND_UNUSED, VAL_MAX,        1, 1'b1, '{ST_DONE, VAL_MAX, 5'd15, 1'b1}},
    '{KIND_DELETE, -32'sd7,        1, 1'b0, '0},
    '{KIND_DUMP,   32'sd0,         1, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  sli_in_if  in_ch ();
  sli_out_if out_ch ();

  sorted_list_insert_delete #(.CAPACITY(CAPACITY)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the table, ascending, and the words still owed by the block
  logic signed [DATA_W-1:0] list_vals [$];
  result_t                  outstanding_words [$];
  int                       mismatch_cnt = 0;

  bit idle_off = 1'b0;  // both sides stream with no gaps while set
  bit hold_req = 1'b0;  // asks the receiver for one long back-pressure stretch

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(8_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Apply one operation to the shadow list and queue the words it causes.
  // With owe_words clear the state moves but nothing is queued (typed rows).
  task automatic apply_list_op(input logic [KIND_W-1:0] k,
                               input logic signed [DATA_W-1:0] v,
                               input bit owe_words);
    int                  pos;
    int                  cnt;
    logic [STATUS_W-1:0] st;
    cnt = list_vals.size();
    if (k == KIND_DUMP) begin
      if (!owe_words) begin
        return;
      end
      if (cnt == 0) begin
        outstanding_words.push_back('{ST_EMPTY, v, FILL_W'(0), 1'b1});
      end else begin
        for (int i = 0; i < cnt; i++) begin
          outstanding_words.push_back('{ST_DONE, list_vals[i], FILL_W'(cnt),
                                        i == cnt - 1});
        end
      end
      return;
    end
    st  = ST_DONE;
    pos = 0;
    if (k == KIND_INSERT) begin
      if (cnt >= CAPACITY) begin
        st = ST_FULL;
      end else begin
        // goes after every stored value that is not greater
        while (pos < cnt && list_vals[pos] <= v) pos++;
        list_vals.insert(pos, v);
      end
    end else if (k == KIND_DELETE) begin
      if (cnt == 0) begin
        st = ST_EMPTY;
      end else begin
        while (pos < cnt && list_vals[pos] != v) pos++;
        if (pos >= cnt) st = ST_NOT_FOUND;
        else list_vals.delete(pos);
      end
    end
    if (owe_words) begin
      outstanding_words.push_back('{st, v, FILL_W'(list_vals.size()), 1'b1});
    end
  endtask

  // Offer one word, idling at random first; returns on the accepting edge.
  task automatic send_word(input logic [KIND_W-1:0] k,
                           input logic signed [DATA_W-1:0] v);
    while (!idle_off && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every owed word has come back.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding_words.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3, 4: return $signed(DATA_W'($urandom_range(16))) - 32'sd8;
      default: return $signed($urandom);
    endcase
  endfunction

  // delete mostly hits a stored value so the table actually drains
  function automatic logic signed [DATA_W-1:0] pick_victim();
    if (list_vals.size() > 0 && $urandom_range(99) < 75)
      return list_vals[$urandom_range(list_vals.size() - 1)];
    return pick_value();
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input seg_mode_t mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      SEG_FILL: begin
        if (roll < 70) return KIND_INSERT;
        if (roll < 80) return KIND_DELETE;
        if (roll < 95) return KIND_DUMP;
      end
      SEG_DRAIN: begin
        if (roll < 70) return KIND_DELETE;
        if (roll < 85) return KIND_INSERT;
        if (roll < 95) return KIND_DUMP;
      end
      default: begin
        if (roll < 40) return KIND_INSERT;
        if (roll < 75) return KIND_DELETE;
        if (roll < 96) return KIND_DUMP;
      end
    endcase
    return KIND_UNUSED;
  endfunction

  // Result side: ready at random, with a long counted hold when asked.
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= idle_off || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Checker: every accepted result word against the oldest owed word.
  result_t want;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (outstanding_words.size() == 0) begin
        flag_mismatch("unexpected word, entry", out_ch.entry, '0);
      end else begin
        want = outstanding_words.pop_front();
        if (out_ch.status !== want.status)
          flag_mismatch("status", DATA_W'(out_ch.status), DATA_W'(want.status));
        if (out_ch.entry !== want.entry)
          flag_mismatch("entry", out_ch.entry, want.entry);
        if (out_ch.fill !== want.fill)
          flag_mismatch("fill", DATA_W'(out_ch.fill), DATA_W'(want.fill));
        if (out_ch.last !== want.last)
          flag_mismatch("last", DATA_W'(out_ch.last), DATA_W'(want.last));
      end
    end
  end

  // Main sequence: reset, directed table, random bursts, drain, verdict.
  initial begin
    int                       sent;
    int                       seg;
    int                       seg_len;
    seg_mode_t                mode;
    logic [KIND_W-1:0]        k;
    logic signed [DATA_W-1:0] v;

    clk         = 1'b0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_INSERT;
    in_ch.value = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; typed rows carry their own answer, the rest use the list
    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int n = 0; n < dir_rows[r].reps; n++) begin
        send_word(dir_rows[r].kind, dir_rows[r].value);
        if (dir_rows[r].typed) begin
          outstanding_words.push_back(dir_rows[r].want);
          apply_list_op(dir_rows[r].kind, dir_rows[r].value, 1'b0);
        end else begin
          apply_list_op(dir_rows[r].kind, dir_rows[r].value, 1'b1);
        end
      end
    end
    wait_drain();

    // random bursts: fill toward full, drain toward empty, or mixed traffic
    sent = 0;
    seg  = 0;
    while (sent < RAND_WORDS) begin
      mode    = seg_mode_t'($urandom_range(2));
      seg_len = $urandom_range(15, 30);
      if (seg_len > RAND_WORDS - sent) seg_len = RAND_WORDS - sent;
      idle_off = (seg == 2);   // one burst streams flat out on both sides
      if (seg == 3) begin
        // back-pressure while stuffing the table so the input must stall
        mode     = SEG_FILL;
        hold_req = 1'b1;
      end
      for (int n = 0; n < seg_len; n++) begin
        k = pick_kind(mode);
        v = (k == KIND_DELETE) ? pick_victim() : pick_value();
        send_word(k, v);
        apply_list_op(k, v, 1'b1);
        sent++;
      end
      // pause the sender until the block has answered everything
      if (seg == 4 || $urandom_range(3) == 0) begin
        wait_drain();
      end
      seg++;
    end
    idle_off = 1'b0;

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && outstanding_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sorted_list_insert_delete.f */
hw/rtl/sli_pkg.sv
hw/rtl/sli_in_if.sv
hw/rtl/sli_out_if.sv
hw/rtl/sli_ctrl.sv
hw/rtl/sli_dp.sv
hw/rtl/sorted_list_insert_delete.sv
dv/tb_top.sv
